/* sv/kbfm_pkg.sv */
`timescale 1ns / 1ps

package kbfm_pkg;

  // Width of one row of the used-frame bitmap.
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  // Configuration register indexes.
  localparam logic [1:0] REG_VM_ENABLED = 2'd0;
  localparam logic [1:0] REG_STACK_BASE = 2'd1;
  localparam logic [1:0] REG_BOOT_BREAK = 2'd2;

  // Configuration reset values.
  localparam logic       VM_ENABLED_RESET = 1'b0;
  localparam logic [7:0] STACK_BASE_RESET = 8'd126;
  localparam logic [7:0] BOOT_BREAK_RESET = 8'd16;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STACK = 2'd1,
    ST_NOMEM = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_DECIDE,
    S_GROW_RD,
    S_GROW_CHK,
    S_REL_PTE,
    S_REL_ROW,
    S_REL_WR,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    sweep_start;
    logic    sweep_step;
    logic    accept;
    logic    start_grow;
    logic    start_shrink;
    logic    commit;
    logic    set_status;
    status_t status;
    logic    search_rd;
    logic    alloc;
    logic    next_row;
    logic    no_frame;
    logic    pte_rd;
    logic    next_page;
    logic    free_rd;
    logic    release_frame;
    logic    load_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic boot_wr;
    logic sweep_last;
    logic collide;
    logic vm_on;
    logic grow;
    logic at_end;
    logic row_has_free;
    logic row_last;
    logic rollback;
    logic pte_valid;
    logic out_free;
  } sts_t;

  // Index of the lowest clear bit of a bitmap row (zero when the row is full).
  function automatic logic [WORD_SHIFT-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [WORD_SHIFT-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = WORD_SHIFT'(i);
      end
    end
    return r;
  endfunction

endpackage

/* sv/kbfm_ctrl.sv */
`timescale 1ns / 1ps

module kbfm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  kbfm_pkg::sts_t  sts,
  output kbfm_pkg::cmd_t  cmd
);

  kbfm_pkg::state_t state;
  kbfm_pkg::state_t state_next;

  // State register; reset starts the clearing sweep of both maps.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kbfm_pkg::S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      kbfm_pkg::S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = kbfm_pkg::S_IDLE;
        end
      end
      kbfm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = kbfm_pkg::S_DECIDE;
        end
      end
      kbfm_pkg::S_DECIDE: begin
        if (sts.collide) begin
          cmd.set_status = 1'b1;
          cmd.status     = kbfm_pkg::ST_STACK;
          state_next     = kbfm_pkg::S_DONE;
        end else if (!sts.vm_on) begin
          cmd.commit     = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = kbfm_pkg::ST_OK;
          state_next     = kbfm_pkg::S_DONE;
        end else if (sts.grow) begin
          cmd.start_grow = 1'b1;
          state_next     = kbfm_pkg::S_GROW_RD;
        end else begin
          cmd.start_shrink = 1'b1;
          state_next       = kbfm_pkg::S_REL_PTE;
        end
      end
      kbfm_pkg::S_GROW_RD: begin
        if (sts.at_end) begin
          cmd.commit     = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = kbfm_pkg::ST_OK;
          state_next     = kbfm_pkg::S_DONE;
        end else begin
          cmd.search_rd = 1'b1;
          state_next    = kbfm_pkg::S_GROW_CHK;
        end
      end
      kbfm_pkg::S_GROW_CHK: begin
        if (sts.row_has_free) begin
          cmd.alloc     = 1'b1;
          cmd.next_page = 1'b1;
          state_next    = kbfm_pkg::S_GROW_RD;
        end else if (sts.row_last) begin
          cmd.no_frame = 1'b1;
          state_next   = kbfm_pkg::S_REL_PTE;
        end else begin
          cmd.next_row = 1'b1;
          state_next   = kbfm_pkg::S_GROW_RD;
        end
      end
      kbfm_pkg::S_REL_PTE: begin
        if (sts.at_end) begin
          cmd.set_status = 1'b1;
          if (sts.rollback) begin
            cmd.status = kbfm_pkg::ST_NOMEM;
          end else begin
            cmd.commit = 1'b1;
            cmd.status = kbfm_pkg::ST_OK;
          end
          state_next = kbfm_pkg::S_DONE;
        end else begin
          cmd.pte_rd = 1'b1;
          state_next = kbfm_pkg::S_REL_ROW;
        end
      end
      kbfm_pkg::S_REL_ROW: begin
        if (sts.rollback || sts.pte_valid) begin
          cmd.free_rd = 1'b1;
          state_next  = kbfm_pkg::S_REL_WR;
        end else begin
          cmd.next_page = 1'b1;
          state_next    = kbfm_pkg::S_REL_PTE;
        end
      end
      kbfm_pkg::S_REL_WR: begin
        cmd.release_frame = 1'b1;
        cmd.next_page     = 1'b1;
        state_next        = kbfm_pkg::S_REL_PTE;
      end
      kbfm_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = kbfm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kbfm_pkg::S_SWEEP;
      end
    endcase

    // A boot break write restarts the initialisation sweep from any state.
    if (sts.boot_wr) begin
      cmd             = '0;
      cmd.sweep_start = 1'b1;
      in_ready        = 1'b0;
      state_next      = kbfm_pkg::S_SWEEP;
    end
  end

endmodule

/* sv/kbfm_datapath.sv */
`timescale 1ns / 1ps

module kbfm_datapath #(
  parameter int FRAME_COUNT = 128,
  parameter int NUM_PAGES   = 128,
  parameter int PAGE_SHIFT  = 13
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic [31:0]     request_address,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status,
  output logic [7:0]      break_page,
  input  kbfm_pkg::cmd_t  cmd,
  output kbfm_pkg::sts_t  sts
);

  localparam int WB        = kbfm_pkg::WORD_BITS;
  localparam int WS        = kbfm_pkg::WORD_SHIFT;
  localparam int ROWS      = (FRAME_COUNT + WB - 1) / WB;
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FW        = $clog2(FRAME_COUNT);
  localparam int PW        = $clog2(NUM_PAGES);
  localparam int SWEEP_LEN = (ROWS > NUM_PAGES) ? ROWS : NUM_PAGES;
  localparam int SW        = $clog2(SWEEP_LEN + 1);
  localparam logic [32:0] ROUND_ADD = 33'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [7:0]  BREAK_RESET =
      (32'(kbfm_pkg::BOOT_BREAK_RESET) < NUM_PAGES) ? kbfm_pkg::BOOT_BREAK_RESET
                                                    : 8'(NUM_PAGES);

  // Configuration registers.
  logic       vm_en;
  logic [7:0] stack_base;
  logic [7:0] boot_break;

  // Request state.
  logic [7:0]        cur_break;
  logic [7:0]        np;
  logic              collide;
  logic [7:0]        idx;
  logic [7:0]        end_page;
  logic [RW-1:0]     row;
  logic [RW-1:0]     hint;
  logic              rollback;
  kbfm_pkg::status_t st;
  logic [SW-1:0]     sweep_cnt;

  // Used-frame bitmap in rows and the page table (valid bit on top of the frame).
  logic [WB-1:0] bitmap [ROWS];
  logic [FW:0]   pte [NUM_PAGES];
  logic [WB-1:0] row_q;
  logic [FW:0]   pte_q;

  logic [32:0]   np_full;
  logic [31:0]   limit;
  logic          boot_wr;
  logic          out_free;
  logic [PW-1:0] pte_addr;
  logic [WS-1:0] free_bit;
  logic [FW-1:0] alloc_frame;
  logic [FW-1:0] rel_frame;
  logic [RW-1:0] rel_row;
  logic [WS-1:0] rel_bit;
  logic [WB-1:0] sweep_row;
  logic [FW:0]   sweep_pte;

  logic          bm_we;
  logic [RW-1:0] bm_waddr;
  logic [WB-1:0] bm_wdata;
  logic          bm_re;
  logic [RW-1:0] bm_raddr;
  logic          pte_we;
  logic [PW-1:0] pte_waddr;
  logic [FW:0]   pte_wdata;

  // Page rounding without wrap and the collision limit.
  assign np_full  = (33'(request_address) + ROUND_ADD) >> PAGE_SHIFT;
  assign limit    = (32'(stack_base) < NUM_PAGES) ? 32'(stack_base) : 32'(NUM_PAGES);
  assign boot_wr  = cfg_write && (cfg_index == kbfm_pkg::REG_BOOT_BREAK);
  assign out_free = !out_valid || out_ready;

  // Addresses and frame numbers for allocation and release.
  assign pte_addr    = PW'(idx);
  assign free_bit    = kbfm_pkg::lowest_zero(row_q);
  assign alloc_frame = FW'({row, free_bit});
  assign rel_frame   = pte_q[FW-1:0];
  assign rel_row     = RW'(rel_frame >> WS);
  assign rel_bit     = WS'(rel_frame);

  // Initial contents of the row and the page entry at the sweep position.
  always_comb begin
    logic [31:0] f;
    logic [31:0] p;
    logic        v;
    for (int b = 0; b < WB; b++) begin
      f            = (32'(sweep_cnt) << WS) + 32'(b);
      sweep_row[b] = (f < 32'(boot_break)) || (f >= 32'(FRAME_COUNT - 2));
    end
    p         = 32'(sweep_cnt);
    v         = (p < 32'(boot_break)) && (p < 32'(FRAME_COUNT));
    sweep_pte = {v, v ? FW'(p) : FW'(0)};
  end

  // Write and read port selection for both memories.
  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = row;
    bm_wdata  = row_q;
    pte_we    = 1'b0;
    pte_waddr = pte_addr;
    pte_wdata = pte_q;
    if (cmd.sweep_step) begin
      bm_we     = 32'(sweep_cnt) < 32'(ROWS);
      bm_waddr  = sweep_cnt[RW-1:0];
      bm_wdata  = sweep_row;
      pte_we    = 32'(sweep_cnt) < 32'(NUM_PAGES);
      pte_waddr = sweep_cnt[PW-1:0];
      pte_wdata = sweep_pte;
    end else if (cmd.alloc) begin
      bm_we     = 1'b1;
      bm_waddr  = row;
      bm_wdata  = row_q | (WB'(1) << free_bit);
      pte_we    = 1'b1;
      pte_wdata = {1'b1, alloc_frame};
    end else if (cmd.release_frame) begin
      bm_we     = 1'b1;
      bm_waddr  = rel_row;
      bm_wdata  = row_q & ~(WB'(1) << rel_bit);
      pte_we    = 1'b1;
      pte_wdata = {1'b0, rel_frame};
    end
  end

  assign bm_re    = cmd.search_rd || cmd.free_rd;
  assign bm_raddr = cmd.search_rd ? row : rel_row;

  // Bitmap memory with registered read.
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap[bm_waddr] <= bm_wdata;
    end
    if (bm_re) begin
      row_q <= bitmap[bm_raddr];
    end
  end

  // Page table memory with registered read.
  always_ff @(posedge clk) begin
    if (pte_we) begin
      pte[pte_waddr] <= pte_wdata;
    end
    if (cmd.pte_rd) begin
      pte_q <= pte[pte_addr];
    end
  end

  // Configuration writes; an unused index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      vm_en      <= kbfm_pkg::VM_ENABLED_RESET;
      stack_base <= kbfm_pkg::STACK_BASE_RESET;
      boot_break <= kbfm_pkg::BOOT_BREAK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        kbfm_pkg::REG_VM_ENABLED: vm_en      <= cfg_data[0];
        kbfm_pkg::REG_STACK_BASE: stack_base <= cfg_data;
        kbfm_pkg::REG_BOOT_BREAK: boot_break <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Control state: break, sweep counter, search hint, rollback flag, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_break <= BREAK_RESET;
      sweep_cnt <= '0;
      hint      <= '0;
      rollback  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (boot_wr) begin
        cur_break <= (32'(cfg_data) < NUM_PAGES) ? cfg_data : 8'(NUM_PAGES);
      end else if (cmd.commit) begin
        cur_break <= np;
      end

      if (cmd.sweep_start) begin
        sweep_cnt <= '0;
      end else if (cmd.sweep_step) begin
        sweep_cnt <= sweep_cnt + SW'(1);
      end

      // All rows below the hint are full.
      if (cmd.sweep_start) begin
        hint <= '0;
      end else if (cmd.alloc) begin
        hint <= row;
      end else if (cmd.release_frame && (rel_row < hint)) begin
        hint <= rel_row;
      end

      if (cmd.start_grow || cmd.start_shrink) begin
        rollback <= 1'b0;
      end else if (cmd.no_frame) begin
        rollback <= 1'b1;
      end

      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request payload registers and the page walk.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      np      <= np_full[7:0];
      collide <= np_full >= {1'b0, limit};
    end
    if (cmd.start_grow) begin
      idx      <= cur_break;
      end_page <= np;
    end else if (cmd.start_shrink) begin
      idx      <= np;
      end_page <= cur_break;
    end else if (cmd.no_frame) begin
      idx      <= cur_break;
      end_page <= idx;
    end else if (cmd.next_page) begin
      idx <= idx + 8'd1;
    end
    if (cmd.start_grow) begin
      row <= hint;
    end else if (cmd.next_row) begin
      row <= row + RW'(1);
    end
    if (cmd.set_status) begin
      st <= cmd.status;
    end
    if (cmd.load_result) begin
      status     <= st;
      break_page <= cur_break;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.boot_wr      = boot_wr;
    sts.sweep_last   = sweep_cnt == SW'(SWEEP_LEN - 1);
    sts.collide      = collide;
    sts.vm_on        = vm_en;
    sts.grow         = np > cur_break;
    sts.at_end       = idx == end_page;
    sts.row_has_free = row_q != '1;
    sts.row_last     = row == RW'(ROWS - 1);
    sts.rollback     = rollback;
    sts.pte_valid    = pte_q[FW];
    sts.out_free     = out_free;
  end

`ifndef SYNTHESIS
  // The break never leaves the page table.
  a_break_bound: assert property (@(posedge clk) disable iff (rst)
      32'(cur_break) <= 32'(NUM_PAGES))
    else $error("break beyond page table");

  // A result is only loaded into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
      cmd.load_result |-> out_free)
    else $error("result overwritten");

  // Allocation only takes a clear bit and never during a rollback.
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
      cmd.alloc |-> (row_q != '1) && !rollback)
    else $error("allocation from a full row");

  // Released frames are real frames.
  a_release_frame: assert property (@(posedge clk) disable iff (rst)
      cmd.release_frame |-> 32'(rel_frame) < 32'(FRAME_COUNT))
    else $error("release of a frame out of range");

  // A committed break lies below the collision limit.
  a_commit_limit: assert property (@(posedge clk) disable iff (rst)
      cmd.commit |-> 32'(np) < limit)
    else $error("break committed at or above stack base");
`endif

endmodule

/* sv/kernel_break_frame_mapper_core.sv */
`timescale 1ns / 1ps

// Kernel break setter with a bitmap frame allocator and a kernel page table.
// Input channel (in_valid/in_ready, request_address): one transfer per request
// for a new break byte address, rounded up to a page. Output channel
// (out_valid/out_ready, status, break_page): one transfer per request, in
// order, unless a boot break write drops it. The configuration port (cfg_write,
// cfg_index, cfg_data) takes a write every cycle it is enabled; writing the boot
// break page rebuilds both maps. A stack collision or a request with paging off
// passes the decide and done states before its result is registered for output.
// A growing request reads the bitmap one row of 32 frames at a time from the
// search hint, through the single read port of the bitmap memory, for each new
// page. Shrinking reads each page entry and, for a mapped page, its bitmap row
// before it releases the frame. Running out of frames rolls back the pages
// mapped so far. One request is worked on at a time; a new one is taken while
// the last result waits. After reset, and after a boot break write, a clearing
// sweep over every bitmap row and page table entry rebuilds the maps; in_ready
// stays low during it. When the receiver stalls the result is held in the
// output register and a following request stops before its result.

module kernel_break_frame_mapper_core #(
  parameter int FRAME_COUNT = 128,
  parameter int NUM_PAGES   = 128,
  parameter int PAGE_SHIFT  = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] request_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  break_page
);

  kbfm_pkg::cmd_t cmd;
  kbfm_pkg::sts_t sts;

  // Sequencer for sweep, allocation and release.
  kbfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Maps, configuration and result register.
  kbfm_datapath #(
    .FRAME_COUNT (FRAME_COUNT),
    .NUM_PAGES   (NUM_PAGES),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .request_address (request_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .break_page      (break_page),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
